// File: hw/rtl/mndf_pkg.sv
// Package for the MOVERS-NWSC dissipative flux block: word format, codes,
// controller/datapath command types and the fixed micro-program.
// No dependencies.
`default_nettype none

package mndf_pkg;

  // Fixed-point word format (signed Q16.16)
  localparam int W  = 32;
  localparam int F  = 16;
  localparam int DW = W + F;   // divider dividend width
  localparam int CW = 31;      // config register width

  typedef logic signed [W-1:0] word_t;

  localparam word_t WMAX = {1'b0, {(W-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(W-1){1'b0}}};

  // Config register reset values
  localparam logic [CW-1:0] IGM1_RST = 31'd163840;
  localparam logic [CW-1:0] GAIN_RST = 31'd13763;
  localparam logic [CW-1:0] EPS_RST  = 31'd1;

  typedef enum logic [1:0] {
    CFG_IGM1 = 2'd0,
    CFG_GAIN = 2'd1,
    CFG_EPS  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OPC_LEFT  = 1'b0,
    OPC_RIGHT = 1'b1
  } opc_e;

  typedef enum logic [2:0] {
    OP_MUL, OP_SENS, OP_ADD, OP_SUB, OP_AVG, OP_ABS, OP_ALPHA, OP_DIV
  } op_e;

  // Operand sources: temporaries live in RAM (bit 5 clear), the rest are registers
  typedef enum logic [5:0] {
    S_T0 = 6'd0, S_T1 = 6'd1, S_VNL = 6'd2, S_VNR = 6'd3,
    S_A0 = 6'd4, S_DU0 = 6'd5, S_SEN = 6'd6, S_AP = 6'd7,
    S_A1 = 6'd8, S_DU1 = 6'd9, S_A2 = 6'd10, S_DU2 = 6'd11,
    S_A3 = 6'd12, S_DU3 = 6'd13,
    S_LRHO = 6'd32, S_LU = 6'd33, S_LV = 6'd34, S_LP = 6'd35,
    S_LC0 = 6'd36, S_LC1 = 6'd37, S_LC2 = 6'd38, S_LC3 = 6'd39,
    S_RRHO = 6'd40, S_RU = 6'd41, S_RV = 6'd42, S_RP = 6'd43,
    S_RC0 = 6'd44, S_RC1 = 6'd45, S_RC2 = 6'd46, S_RC3 = 6'd47,
    S_NX = 6'd48, S_NY = 6'd49, S_IG = 6'd50, S_SG = 6'd51
  } src_e;

  // Destinations: temporaries (bit 4 clear) or flux staging registers
  typedef enum logic [4:0] {
    D_T0 = 5'd0, D_T1 = 5'd1, D_VNL = 5'd2, D_VNR = 5'd3,
    D_A0 = 5'd4, D_DU0 = 5'd5, D_SEN = 5'd6, D_AP = 5'd7,
    D_A1 = 5'd8, D_DU1 = 5'd9, D_A2 = 5'd10, D_DU2 = 5'd11,
    D_A3 = 5'd12, D_DU3 = 5'd13,
    D_F0 = 5'd16, D_F1 = 5'd17, D_F2 = 5'd18, D_F3 = 5'd19
  } dst_e;

  localparam int TMP_DEPTH = 16;
  localparam int TA = $clog2(TMP_DEPTH);

  typedef struct packed {
    op_e  op;
    src_e a;
    src_e b;
    dst_e dst;
  } uop_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_WB, ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;   // input item taken this cycle
    logic rd;       // read temporaries for uop
    logic exec;     // evaluate uop
    logic wb;       // write uop result
    logic publish;  // move flux staging to output registers
    uop_t uop;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
  } sts_t;

  localparam int NUM_UOPS = 71;
  localparam int PCW = $clog2(NUM_UOPS);

  // Micro-program for one face
  localparam uop_t PROG [NUM_UOPS] = '{
    // normal speeds
    '{OP_MUL, S_LU, S_NX, D_T0},
    '{OP_MUL, S_LV, S_NY, D_T1},
    '{OP_ADD, S_T0, S_T1, D_VNL},
    '{OP_MUL, S_RU, S_NX, D_T0},
    '{OP_MUL, S_RV, S_NY, D_T1},
    '{OP_ADD, S_T0, S_T1, D_VNR},
    // pressure sensor
    '{OP_SUB, S_RP, S_LP, D_T0},
    '{OP_ADD, S_RP, S_LP, D_T1},
    '{OP_DIV, S_T0, S_T1, D_T0},
    '{OP_SENS, S_SG, S_T0, D_SEN},
    // upwind coefficient
    '{OP_ABS, S_VNR, S_T0, D_T0},
    '{OP_ABS, S_VNL, S_T0, D_T1},
    '{OP_AVG, S_T0, S_T1, D_AP},
    // mass
    '{OP_MUL, S_RRHO, S_VNR, D_T0},
    '{OP_MUL, S_LRHO, S_VNL, D_T1},
    '{OP_SUB, S_T0, S_T1, D_A0},
    '{OP_SUB, S_RC0, S_LC0, D_DU0},
    '{OP_ALPHA, S_DU0, S_A0, D_A0},
    // x momentum
    '{OP_MUL, S_RRHO, S_RU, D_T0},
    '{OP_MUL, S_T0, S_VNR, D_T0},
    '{OP_MUL, S_RP, S_NX, D_T1},
    '{OP_ADD, S_T0, S_T1, D_A1},
    '{OP_MUL, S_LRHO, S_LU, D_T0},
    '{OP_MUL, S_T0, S_VNL, D_T0},
    '{OP_MUL, S_LP, S_NX, D_T1},
    '{OP_ADD, S_T0, S_T1, D_T0},
    '{OP_SUB, S_A1, S_T0, D_A1},
    '{OP_SUB, S_RC1, S_LC1, D_DU1},
    '{OP_ALPHA, S_DU1, S_A1, D_A1},
    // y momentum
    '{OP_MUL, S_RRHO, S_RV, D_T0},
    '{OP_MUL, S_T0, S_VNR, D_T0},
    '{OP_MUL, S_RP, S_NY, D_T1},
    '{OP_ADD, S_T0, S_T1, D_A2},
    '{OP_MUL, S_LRHO, S_LV, D_T0},
    '{OP_MUL, S_T0, S_VNL, D_T0},
    '{OP_MUL, S_LP, S_NY, D_T1},
    '{OP_ADD, S_T0, S_T1, D_T0},
    '{OP_SUB, S_A2, S_T0, D_A2},
    '{OP_SUB, S_RC2, S_LC2, D_DU2},
    '{OP_ALPHA, S_DU2, S_A2, D_A2},
    // energy, right enthalpy
    '{OP_MUL, S_RU, S_RU, D_T0},
    '{OP_MUL, S_RV, S_RV, D_T1},
    '{OP_AVG, S_T0, S_T1, D_T0},
    '{OP_MUL, S_RRHO, S_T0, D_T0},
    '{OP_MUL, S_RP, S_IG, D_T1},
    '{OP_ADD, S_T1, S_T0, D_T0},
    '{OP_ADD, S_T0, S_RP, D_T0},
    '{OP_MUL, S_T0, S_VNR, D_A3},
    // energy, left enthalpy
    '{OP_MUL, S_LU, S_LU, D_T0},
    '{OP_MUL, S_LV, S_LV, D_T1},
    '{OP_AVG, S_T0, S_T1, D_T0},
    '{OP_MUL, S_LRHO, S_T0, D_T0},
    '{OP_MUL, S_LP, S_IG, D_T1},
    '{OP_ADD, S_T1, S_T0, D_T0},
    '{OP_ADD, S_T0, S_LP, D_T0},
    '{OP_MUL, S_T0, S_VNL, D_T0},
    '{OP_SUB, S_A3, S_T0, D_A3},
    '{OP_SUB, S_RC3, S_LC3, D_DU3},
    '{OP_ALPHA, S_DU3, S_A3, D_A3},
    // final flux components
    '{OP_MUL, S_SEN, S_A0, D_T0},
    '{OP_MUL, S_AP, S_DU0, D_T1},
    '{OP_AVG, S_T0, S_T1, D_F0},
    '{OP_MUL, S_SEN, S_A1, D_T0},
    '{OP_MUL, S_AP, S_DU1, D_T1},
    '{OP_AVG, S_T0, S_T1, D_F1},
    '{OP_MUL, S_SEN, S_A2, D_T0},
    '{OP_MUL, S_AP, S_DU2, D_T1},
    '{OP_AVG, S_T0, S_T1, D_F2},
    '{OP_MUL, S_SEN, S_A3, D_T0},
    '{OP_MUL, S_AP, S_DU3, D_T1},
    '{OP_AVG, S_T0, S_T1, D_F3}
  };

endpackage

`default_nettype wire

// File: hw/rtl/movers_nwsc_dissipative_flux.sv
// MOVERS-NWSC dissipative flux for one face of a 2D Euler solver, signed
// Q16.16 with saturation. Send the left cell as an item with opcode 0 (taken
// with no result), then the right cell and scaled face normal with
// opcode 1, which yields one item of four flux components. A right item runs
// a 71-step micro-program on one shared multiplier and saturating ALU, each
// step going through read, execute and write-back states. The pressure sensor
// uses a 48-step bit-serial divide, during which its step waits in a divide
// state. The next item is taken as soon as the result sits in the output
// register. Config writes are always taken.
`default_nettype none

module movers_nwsc_dissipative_flux (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    opcode_i,
  input  wire mndf_pkg::word_t         density_i,
  input  wire mndf_pkg::word_t         x_velocity_i,
  input  wire mndf_pkg::word_t         y_velocity_i,
  input  wire mndf_pkg::word_t         pressure_i,
  input  wire mndf_pkg::word_t         cons_mass_i,
  input  wire mndf_pkg::word_t         cons_xmom_i,
  input  wire mndf_pkg::word_t         cons_ymom_i,
  input  wire mndf_pkg::word_t         cons_energy_i,
  input  wire mndf_pkg::word_t         normal_x_scaled_i,
  input  wire mndf_pkg::word_t         normal_y_scaled_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output mndf_pkg::word_t              flux_mass_o,
  output mndf_pkg::word_t              flux_xmom_o,
  output mndf_pkg::word_t              flux_ymom_o,
  output mndf_pkg::word_t              flux_energy_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [1:0]              cfg_index_i,
  input  wire logic [mndf_pkg::CW-1:0] cfg_data_i
);
  import mndf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  mndf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mndf_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .opcode_i          (opcode_i),
    .density_i         (density_i),
    .x_velocity_i      (x_velocity_i),
    .y_velocity_i      (y_velocity_i),
    .pressure_i        (pressure_i),
    .cons_mass_i       (cons_mass_i),
    .cons_xmom_i       (cons_xmom_i),
    .cons_ymom_i       (cons_ymom_i),
    .cons_energy_i     (cons_energy_i),
    .normal_x_scaled_i (normal_x_scaled_i),
    .normal_y_scaled_i (normal_y_scaled_i),
    .cfg_we_i          (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .flux_mass_o       (flux_mass_o),
    .flux_xmom_o       (flux_xmom_o),
    .flux_ymom_o       (flux_ymom_o),
    .flux_energy_o     (flux_energy_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/mndf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mndf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mndf_div.sv
// Restoring divider, one quotient bit per cycle: saturated (n << F) / d.
// Depends on mndf_pkg.
`default_nettype none

module mndf_div (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [mndf_pkg::W-1:0] num_i,
  input  wire logic [mndf_pkg::W-1:0] den_i,
  output logic                       done_o,
  output mndf_pkg::word_t            quot_o
);
  import mndf_pkg::*;

  localparam int NW = $clog2(DW);

  logic          busy_q, done_q;
  logic [NW-1:0] cnt_q;
  logic [DW-1:0] dvd_q, quo_q;
  logic [W:0]    rem_q, rem_sh;
  logic [W-1:0]  den_q;
  logic          ge;

  // One compare-subtract step
  always_comb begin
    rem_sh = {rem_q[W-1:0], dvd_q[DW-1]};
    ge     = rem_sh >= {1'b0, den_q};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == NW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {num_i, {F{1'b0}}};
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DW-2:0], 1'b0};
      rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = (|quo_q[DW-1:W-1]) ? WMAX : word_t'(quo_q[W-1:0]);

endmodule

`default_nettype wire

// File: hw/rtl/mndf_dp.sv
// Datapath: cell state, config registers, temporaries RAM, multiplier,
// saturating ALU, divider and flux output registers.
// Depends on mndf_pkg, mndf_ram, mndf_div.
`default_nettype none

module mndf_dp (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire mndf_pkg::cmd_t            cmd_i,
  output mndf_pkg::sts_t                 sts_o,
  input  wire logic                      opcode_i,
  input  wire mndf_pkg::word_t           density_i,
  input  wire mndf_pkg::word_t           x_velocity_i,
  input  wire mndf_pkg::word_t           y_velocity_i,
  input  wire mndf_pkg::word_t           pressure_i,
  input  wire mndf_pkg::word_t           cons_mass_i,
  input  wire mndf_pkg::word_t           cons_xmom_i,
  input  wire mndf_pkg::word_t           cons_ymom_i,
  input  wire mndf_pkg::word_t           cons_energy_i,
  input  wire mndf_pkg::word_t           normal_x_scaled_i,
  input  wire mndf_pkg::word_t           normal_y_scaled_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [1:0]                cfg_index_i,
  input  wire logic [mndf_pkg::CW-1:0]   cfg_data_i,
  output mndf_pkg::word_t                flux_mass_o,
  output mndf_pkg::word_t                flux_xmom_o,
  output mndf_pkg::word_t                flux_ymom_o,
  output mndf_pkg::word_t                flux_energy_o
);
  import mndf_pkg::*;

  function automatic word_t sat_add(word_t a, word_t b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return word_t'(s[W-1:0]);
  endfunction

  function automatic word_t sat_sub(word_t a, word_t b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return word_t'(s[W-1:0]);
  endfunction

  function automatic word_t avg_fl(word_t a, word_t b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    return word_t'(s[W:1]);
  endfunction

  function automatic word_t sat_abs(word_t a);
    if (a == WMIN) return WMAX;
    return a[W-1] ? -a : a;
  endfunction

  function automatic logic [W-1:0] mag(word_t a);
    return a[W-1] ? W'(-a) : W'(a);
  endfunction

  // Cell state and config
  word_t l_rho_q, l_u_q, l_v_q, l_p_q, l_c0_q, l_c1_q, l_c2_q, l_c3_q;
  word_t r_rho_q, r_u_q, r_v_q, r_p_q, r_c0_q, r_c1_q, r_c2_q, r_c3_q;
  word_t nx_q, ny_q;
  logic [CW-1:0] igm1_q, gain_q, eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_rho_q <= '0; l_u_q <= '0; l_v_q <= '0; l_p_q <= '0;
      l_c0_q  <= '0; l_c1_q <= '0; l_c2_q <= '0; l_c3_q <= '0;
      igm1_q  <= IGM1_RST;
      gain_q  <= GAIN_RST;
      eps_q   <= EPS_RST;
    end else begin
      if (cmd_i.accept && opcode_i == OPC_LEFT) begin
        l_rho_q <= density_i;   l_u_q  <= x_velocity_i;
        l_v_q   <= y_velocity_i; l_p_q <= pressure_i;
        l_c0_q  <= cons_mass_i; l_c1_q <= cons_xmom_i;
        l_c2_q  <= cons_ymom_i; l_c3_q <= cons_energy_i;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_IGM1: igm1_q <= cfg_data_i;
          CFG_GAIN: gain_q <= cfg_data_i;
          CFG_EPS:  eps_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Right cell and face normal
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && opcode_i == OPC_RIGHT) begin
      r_rho_q <= density_i;    r_u_q  <= x_velocity_i;
      r_v_q   <= y_velocity_i; r_p_q  <= pressure_i;
      r_c0_q  <= cons_mass_i;  r_c1_q <= cons_xmom_i;
      r_c2_q  <= cons_ymom_i;  r_c3_q <= cons_energy_i;
      nx_q    <= normal_x_scaled_i;
      ny_q    <= normal_y_scaled_i;
    end
  end

  // Temporaries: two copies for two read ports
  word_t ram_a, ram_b, res;
  logic  tmp_we;
  logic [W-1:0] ram_a_raw, ram_b_raw;

  assign tmp_we = cmd_i.wb && !cmd_i.uop.dst[4];

  mndf_ram #(.WIDTH(W), .DEPTH(TMP_DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (tmp_we),
    .waddr_i (cmd_i.uop.dst[TA-1:0]),
    .wdata_i (res),
    .re_i    (cmd_i.rd),
    .raddr_i (cmd_i.uop.a[TA-1:0]),
    .rdata_o (ram_a_raw)
  );

  mndf_ram #(.WIDTH(W), .DEPTH(TMP_DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (tmp_we),
    .waddr_i (cmd_i.uop.dst[TA-1:0]),
    .wdata_i (res),
    .re_i    (cmd_i.rd),
    .raddr_i (cmd_i.uop.b[TA-1:0]),
    .rdata_o (ram_b_raw)
  );

  assign ram_a = word_t'(ram_a_raw);
  assign ram_b = word_t'(ram_b_raw);

  // Operand select
  word_t opa, opb;

  function automatic word_t pick(src_e s, word_t ram, word_t lrho, word_t lu, word_t lv,
                                 word_t lp, word_t lc0, word_t lc1, word_t lc2, word_t lc3,
                                 word_t rrho, word_t ru, word_t rv, word_t rp, word_t rc0,
                                 word_t rc1, word_t rc2, word_t rc3, word_t nx, word_t ny,
                                 word_t ig, word_t sg);
    if (!s[5]) return ram;
    case (s)
      S_LRHO: return lrho;
      S_LU:   return lu;
      S_LV:   return lv;
      S_LP:   return lp;
      S_LC0:  return lc0;
      S_LC1:  return lc1;
      S_LC2:  return lc2;
      S_LC3:  return lc3;
      S_RRHO: return rrho;
      S_RU:   return ru;
      S_RV:   return rv;
      S_RP:   return rp;
      S_RC0:  return rc0;
      S_RC1:  return rc1;
      S_RC2:  return rc2;
      S_RC3:  return rc3;
      S_NX:   return nx;
      S_NY:   return ny;
      S_IG:   return ig;
      S_SG:   return sg;
      default: return '0;
    endcase
  endfunction

  always_comb begin
    opa = pick(cmd_i.uop.a, ram_a, l_rho_q, l_u_q, l_v_q, l_p_q, l_c0_q, l_c1_q, l_c2_q,
               l_c3_q, r_rho_q, r_u_q, r_v_q, r_p_q, r_c0_q, r_c1_q, r_c2_q, r_c3_q,
               nx_q, ny_q, word_t'({1'b0, igm1_q}), word_t'({1'b0, gain_q}));
    opb = pick(cmd_i.uop.b, ram_b, l_rho_q, l_u_q, l_v_q, l_p_q, l_c0_q, l_c1_q, l_c2_q,
               l_c3_q, r_rho_q, r_u_q, r_v_q, r_p_q, r_c0_q, r_c1_q, r_c2_q, r_c3_q,
               nx_q, ny_q, word_t'({1'b0, igm1_q}), word_t'({1'b0, gain_q}));
  end

  // ALU for the non-multiply ops
  word_t alu, eps, adf, adu;

  always_comb begin
    eps = word_t'({1'b0, eps_q});
    adf = sat_abs(opb);
    adu = sat_abs(opa);
    case (cmd_i.uop.op)
      OP_ADD: alu = sat_add(opa, opb);
      OP_SUB: alu = sat_sub(opa, opb);
      OP_AVG: alu = avg_fl(opa, opb);
      OP_ABS: alu = sat_abs(opa);
      OP_ALPHA: begin
        // zero-jump test, then flux jump magnitude with the sign of du
        if (adf <= eps && adu >= eps) alu = '0;
        else if (opa > 0)             alu = adf;
        else if (opa < 0)             alu = -adf;
        else                          alu = '0;
      end
      default: alu = '0;
    endcase
  end

  // Execute stage registers
  logic [2*W-1:0] prod_q;
  logic           neg_q, zero_q;
  word_t          alu_q;
  logic           div_start;
  word_t          quot;
  logic           div_done;

  assign div_start = cmd_i.exec && cmd_i.uop.op == OP_DIV;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      prod_q <= mag(opa) * mag(opb);
      neg_q  <= opa[W-1] ^ opb[W-1];
      alu_q  <= alu;
    end
    if (div_start) begin
      zero_q <= opb == '0;
    end
  end

  mndf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mag(opa)),
    .den_i   (mag(opb)),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign sts_o.div_done = div_done;

  // Product rescale and saturation
  logic [2*W-F-1:0] pm, plim;
  word_t            mulres;

  always_comb begin
    pm   = prod_q[2*W-1:F];
    plim = neg_q ? (2*W-F)'({1'b1, {(W-1){1'b0}}}) : (2*W-F)'({(W-1){1'b1}});
    if (pm > plim) mulres = neg_q ? WMIN : WMAX;
    else           mulres = neg_q ? -word_t'(pm[W-1:0]) : word_t'(pm[W-1:0]);
  end

  // Write-back select
  always_comb begin
    case (cmd_i.uop.op)
      OP_MUL:  res = mulres;
      OP_SENS: res = zero_q ? WMAX : mulres;
      OP_DIV:  res = quot;
      default: res = alu_q;
    endcase
  end

  // Flux staging and output registers
  word_t stg_q [4];
  word_t out_q [4];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wb && cmd_i.uop.dst[4]) begin
      stg_q[cmd_i.uop.dst[1:0]] <= res;
    end
    if (cmd_i.publish) begin
      out_q[0] <= stg_q[0];
      out_q[1] <= stg_q[1];
      out_q[2] <= stg_q[2];
      out_q[3] <= stg_q[3];
    end
  end

  assign flux_mass_o   = out_q[0];
  assign flux_xmom_o   = out_q[1];
  assign flux_ymom_o   = out_q[2];
  assign flux_energy_o = out_q[3];

endmodule

`default_nettype wire

// File: hw/rtl/mndf_ctrl.sv
// Controller: sequences the micro-program over the datapath and owns the
// input and output handshakes. Depends on mndf_pkg.
`default_nettype none

module mndf_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic           opcode_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output mndf_pkg::cmd_t      cmd_o,
  input  wire mndf_pkg::sts_t sts_i
);
  import mndf_pkg::*;

  state_e         state_q, state_d;
  logic [PCW-1:0] pc_q, pc_d;
  logic           oval_q, oval_d;
  logic           accept, last, publish;

  assign accept  = in_valid_i && state_q == ST_IDLE;
  assign last    = pc_q == PCW'(NUM_UOPS - 1);
  assign publish = state_q == ST_DONE && (!oval_q || out_ready_i);

  // Next state
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && opcode_i == OPC_RIGHT) begin
          state_d = ST_READ;
          pc_d    = '0;
        end
      end
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: state_d = (PROG[pc_q].op == OP_DIV) ? ST_DIV : ST_WB;
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_WB;
      end
      ST_WB: begin
        if (last) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_READ;
          pc_d    = pc_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (publish) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    oval_d = oval_q;
    if (publish)          oval_d = 1'b1;
    else if (out_ready_i) oval_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      oval_q  <= oval_d;
    end
  end

  // Outputs
  always_comb begin
    in_ready_o    = state_q == ST_IDLE;
    out_valid_o   = oval_q;
    cmd_o.accept  = accept;
    cmd_o.rd      = state_q == ST_READ;
    cmd_o.exec    = state_q == ST_EXEC;
    cmd_o.wb      = state_q == ST_WB;
    cmd_o.publish = publish;
    cmd_o.uop     = PROG[pc_q];
  end

endmodule

`default_nettype wire
